[src/bpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Band-pass IIR shared definitions
// Filter order, field widths, memory geometry, the binomial feedforward taps
// and the control bundle passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package bpf_pkg;

  // Filter configuration.
  localparam int ORDER          = 2;
  localparam int COEF_FRAC_BITS = 24;
  localparam int NUM_TAPS       = 2 * ORDER + 1;
  localparam int FB_TAPS        = 2 * ORDER;

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 32;
  localparam int GAIN_W   = 31;
  localparam int SHIFT_W  = 5;
  localparam int IDX_W    = 4;
  localparam int CFG_W    = 31;
  localparam int CFG_IX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IX_W-1:0] REG_GAIN       = 1'd0;
  localparam logic [CFG_IX_W-1:0] REG_GAIN_SHIFT = 1'd1;

  // History memory: input ring in the lower half, output ring in the upper half.
  localparam int HA_W       = $clog2(NUM_TAPS);
  localparam int HM_W       = HA_W + 1;
  localparam int HIST_MEM_D = 2 ** HM_W;
  localparam int CA_W       = $clog2(FB_TAPS);

  // Sequencer step counter covers every tap index.
  localparam int STEP_W   = $clog2(FB_TAPS + 1);
  localparam int TAP_IX_W = (ORDER + 1 > 1) ? $clog2(ORDER + 1) : 1;

  // Datapath widths.
  localparam int TAP_W          = ORDER + 2;
  localparam int FF_W           = SAMPLE_W + ORDER + 1;
  localparam int MA_W           = COEF_W;
  localparam int MB_W           = FF_W;
  localparam int PROD_W         = MA_W + MB_W;
  localparam int FBS_W          = SAMPLE_W + COEF_W + CA_W + 1;
  localparam int ACC_W          = ((PROD_W > FBS_W) ? PROD_W : FBS_W) + 2;
  localparam int GAIN_PRE_SHIFT = GAIN_W - COEF_FRAC_BITS;

  // Binomial taps of (1 - z^-2)^ORDER, one per even lag.
  typedef logic signed [TAP_W-1:0] tap_row_t [0:ORDER];

  function automatic tap_row_t ff_taps();
    int       c [0:ORDER];
    tap_row_t r;
    for (int j = 0; j <= ORDER; j++) begin
      c[j] = (j == 0) ? 1 : 0;
    end
    // Pascal's triangle, built by additions only.
    for (int n = 1; n <= ORDER; n++) begin
      for (int j = ORDER; j >= 1; j--) begin
        if (j <= n) begin
          c[j] = c[j] + c[j-1];
        end
      end
    end
    for (int j = 0; j <= ORDER; j++) begin
      r[j] = TAP_W'(((j % 2) == 1) ? -c[j] : c[j]);
    end
    return r;
  endfunction

  localparam tap_row_t FF_TAP = ff_taps();

  // Operation tag carried down the multiply-accumulate pipeline.
  typedef enum logic [1:0] {
    OP_NONE,
    OP_FF,
    OP_FB,
    OP_GAIN
  } op_t;

  // Sequencer to datapath control bundle.
  typedef struct packed {
    op_t               op;
    logic [STEP_W-1:0] step;
    logic              clear;
    logic              finish;
    logic              hist_ok;
    logic              coef_ok;
  } dp_ctl_t;

endpackage

[src/bpf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module bpf_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bpf_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Band-pass IIR datapath
// Shared multiplier with a registered product, feedforward and feedback
// accumulators, the gain scaling and the rounding and saturating output stage.
// ----------------------------------------------------------------------------
module bpf_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  bpf_pkg::dp_ctl_t                    ctl,
  input  logic [bpf_pkg::SAMPLE_W-1:0]        hist_rdata,
  input  logic [bpf_pkg::COEF_W-1:0]          coef_rdata,
  input  logic [bpf_pkg::GAIN_W-1:0]          gain,
  input  logic [bpf_pkg::SHIFT_W-1:0]         gain_shift,
  output logic signed [bpf_pkg::SAMPLE_W-1:0] y,
  output logic signed [bpf_pkg::SAMPLE_W-1:0] filtered
);

  localparam int ACC_W = bpf_pkg::ACC_W;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(2 ** (bpf_pkg::SAMPLE_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(2 ** (bpf_pkg::COEF_FRAC_BITS - 1));

  bpf_pkg::op_t                         op1;
  bpf_pkg::op_t                         op2;
  logic [bpf_pkg::STEP_W-1:0]           step1;
  logic signed [bpf_pkg::MA_W-1:0]      ma;
  logic signed [bpf_pkg::MB_W-1:0]      mb;
  logic signed [bpf_pkg::PROD_W-1:0]    prod;
  logic signed [bpf_pkg::PROD_W-1:0]    prod_sh;
  logic signed [bpf_pkg::FF_W-1:0]      ff_acc;
  logic signed [ACC_W-1:0]              fb_acc;
  logic signed [ACC_W-1:0]              fwd;
  logic signed [ACC_W-1:0]              acc;
  logic signed [ACC_W-1:0]              yw;
  logic signed [bpf_pkg::SAMPLE_W-1:0]  x_s;
  logic signed [bpf_pkg::COEF_W-1:0]    c_s;

  // Entries never written read as zero.
  assign x_s = ctl.hist_ok ? $signed(hist_rdata) : '0;
  assign c_s = ctl.coef_ok ? $signed(coef_rdata) : '0;

  // Multiplier operand selection for the operation now in stage one.
  always_comb begin
    case (op1)
      bpf_pkg::OP_FF: begin
        ma = bpf_pkg::MA_W'(bpf_pkg::FF_TAP[step1[bpf_pkg::TAP_IX_W-1:0]]);
        mb = bpf_pkg::MB_W'(x_s);
      end
      bpf_pkg::OP_FB: begin
        ma = c_s;
        mb = bpf_pkg::MB_W'(x_s);
      end
      bpf_pkg::OP_GAIN: begin
        ma = bpf_pkg::MA_W'($signed({1'b0, gain}));
        mb = ff_acc;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Gain product brought to the coefficient scale, then the user shift.
  assign prod_sh = (prod >>> bpf_pkg::GAIN_PRE_SHIFT) >>> gain_shift;

  // Output: round, drop the fraction and saturate.
  assign acc = fwd - fb_acc + HALF;
  assign yw  = acc >>> bpf_pkg::COEF_FRAC_BITS;

  always_comb begin
    if (yw > SAT_HI) begin
      y = bpf_pkg::SAMPLE_W'(SAT_HI);
    end else if (yw < SAT_LO) begin
      y = bpf_pkg::SAMPLE_W'(SAT_LO);
    end else begin
      y = bpf_pkg::SAMPLE_W'(yw);
    end
  end

  // Pipeline tags.
  always_ff @(posedge clk) begin
    if (rst) begin
      op1 <= bpf_pkg::OP_NONE;
      op2 <= bpf_pkg::OP_NONE;
    end else begin
      op1 <= ctl.op;
      op2 <= op1;
    end
  end

  // Product register, accumulators and output register.
  always_ff @(posedge clk) begin
    step1 <= ctl.step;
    prod  <= ma * mb;
    if (ctl.clear) begin
      ff_acc <= '0;
      fb_acc <= '0;
    end else begin
      case (op2)
        bpf_pkg::OP_FF:   ff_acc <= ff_acc + bpf_pkg::FF_W'(prod);
        bpf_pkg::OP_FB:   fb_acc <= fb_acc + ACC_W'(prod);
        bpf_pkg::OP_GAIN: fwd    <= ACC_W'(prod_sh);
        default: ;
      endcase
    end
    if (ctl.finish) begin
      filtered <= y;
    end
  end

endmodule

[src/bpf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Band-pass IIR sequencer
// Accepts transactions, steps the memory reads for each tap, tracks the ring
// pointers and entry valid bits, and owns the output handshake.
// ----------------------------------------------------------------------------
module bpf_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             mode,
  input  logic [bpf_pkg::IDX_W-1:0]        coef_index,
  input  logic [bpf_pkg::SAMPLE_W-1:0]     sample,
  input  logic [bpf_pkg::SAMPLE_W-1:0]     y,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             hist_we,
  output logic [bpf_pkg::HM_W-1:0]         hist_waddr,
  output logic [bpf_pkg::SAMPLE_W-1:0]     hist_wdata,
  output logic [bpf_pkg::HM_W-1:0]         hist_raddr,
  output logic                             coef_we,
  output logic [bpf_pkg::CA_W-1:0]         coef_waddr,
  output logic [bpf_pkg::CA_W-1:0]         coef_raddr,
  output bpf_pkg::dp_ctl_t                 ctl
);

  localparam int HA_W   = bpf_pkg::HA_W;
  localparam int CA_W   = bpf_pkg::CA_W;
  localparam int STEP_W = bpf_pkg::STEP_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FF,
    S_FB,
    S_GAIN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [STEP_W-1:0]   step;
  logic [STEP_W-1:0]   step_next;
  logic [HA_W-1:0]     in_head;
  logic [HA_W-1:0]     in_head_next;
  logic [CA_W-1:0]     out_head;
  logic [CA_W-1:0]     out_head_next;
  logic                out_valid_next;
  logic                hv_q;
  logic                cv_q;
  logic                hist_valid [bpf_pkg::HIST_MEM_D];
  logic                coef_valid [bpf_pkg::FB_TAPS];
  logic                accept;
  logic                finish;
  logic                coef_in_range;
  logic [HA_W-1:0]     lag;
  logic [CA_W-1:0]     out_wr_slot;
  logic [CA_W-1:0]     out_rd_slot;

  assign in_stall      = (state != S_IDLE);
  assign accept        = in_valid && !in_stall;
  assign coef_in_range = (coef_index != '0) &&
                         (coef_index <= bpf_pkg::IDX_W'(bpf_pkg::FB_TAPS));
  assign lag           = HA_W'({step, 1'b0});

  // Output ring slots wrap at the ring size.
  assign out_wr_slot = out_head + CA_W'(1);
  assign out_rd_slot = out_head - step[CA_W-1:0];

  // Next state, memory ports and pipeline issue.
  always_comb begin
    state_next     = state;
    step_next      = step;
    in_head_next   = in_head;
    out_head_next  = out_head;
    out_valid_next = out_valid;
    hist_we        = 1'b0;
    hist_waddr     = {1'b0, in_head + HA_W'(1)};
    hist_wdata     = sample;
    hist_raddr     = {1'b0, in_head - lag};
    coef_we        = 1'b0;
    coef_waddr     = CA_W'(coef_index - bpf_pkg::IDX_W'(1));
    coef_raddr     = step[CA_W-1:0];
    ctl.op         = bpf_pkg::OP_NONE;
    ctl.clear      = 1'b0;
    ctl.step       = step;
    ctl.hist_ok    = hv_q;
    ctl.coef_ok    = cv_q;
    finish         = 1'b0;

    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (accept && !mode) begin
          // New sample goes in at the head of the input ring.
          hist_we      = 1'b1;
          in_head_next = in_head + HA_W'(1);
          ctl.clear    = 1'b1;
          step_next    = '0;
          state_next   = S_FF;
        end else if (accept && mode && coef_in_range) begin
          coef_we = 1'b1;
        end
      end
      S_FF: begin
        ctl.op = bpf_pkg::OP_FF;
        if (step == STEP_W'(bpf_pkg::ORDER)) begin
          step_next  = '0;
          state_next = S_FB;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_FB: begin
        // Output lag step+1 pairs with coefficient entry step.
        ctl.op     = bpf_pkg::OP_FB;
        hist_raddr = {1'b1, HA_W'(out_rd_slot)};
        if (step == STEP_W'(bpf_pkg::FB_TAPS - 1)) begin
          step_next  = '0;
          state_next = S_GAIN;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_GAIN: begin
        ctl.op     = bpf_pkg::OP_GAIN;
        step_next  = '0;
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        // Let the gain product and last feedback term land.
        if (step == STEP_W'(1)) begin
          state_next = S_FINISH;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_FINISH: begin
        if (!(out_valid && out_stall)) begin
          finish         = 1'b1;
          hist_we        = 1'b1;
          hist_waddr     = {1'b1, HA_W'(out_wr_slot)};
          hist_wdata     = y;
          out_head_next  = out_wr_slot;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    ctl.finish = finish;
  end

  // State, pointers, valid bits and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      in_head   <= '0;
      out_head  <= '0;
      out_valid <= 1'b0;
      hv_q      <= 1'b0;
      cv_q      <= 1'b0;
      for (int i = 0; i < bpf_pkg::HIST_MEM_D; i++) begin
        hist_valid[i] <= 1'b0;
      end
      for (int i = 0; i < bpf_pkg::FB_TAPS; i++) begin
        coef_valid[i] <= 1'b0;
      end
    end else begin
      state     <= state_next;
      step      <= step_next;
      in_head   <= in_head_next;
      out_head  <= out_head_next;
      out_valid <= out_valid_next;
      hv_q      <= hist_valid[hist_raddr];
      cv_q      <= coef_valid[coef_raddr];
      if (hist_we) begin
        hist_valid[hist_waddr] <= 1'b1;
      end
      if (coef_we) begin
        coef_valid[coef_waddr] <= 1'b1;
      end
    end
  end

  // A result is only produced into a free output register.
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    finish |-> !(out_valid && out_stall))
    else $error("result produced while output register held");

  // The tap reads of the history never overlap a history write.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_FF || state == S_FB) |-> !hist_we)
    else $error("history write during tap reads");

  // An accepted sample starts the feedforward pass next cycle.
  a_sample_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && !mode) |=> (state == S_FF))
    else $error("sample transaction did not start the filter pass");

  // The output valid rises only after a finish.
  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(finish))
    else $error("output valid raised without a result");

endmodule

[src/bandpass_iir_direct_form.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Band-pass IIR filter, direct form I
// Signed 16-bit samples through a (1 - z^-2)^ORDER feedforward section, gain
// scaling and a loaded feedback section, saturated to 16 bits.
// ----------------------------------------------------------------------------
// A sample transaction steps through the feedforward, feedback, gain, drain
// and finish states from acceptance until the block accepts again; a
// coefficient load produces no result. The pace is set by the single shared
// multiplier and the single read port of the history memory: one feedforward
// tap or one feedback tap is read and multiplied per cycle, followed by the
// gain multiply and a pipeline drain. Input and output histories
// live in one RAM as two rings and the feedback coefficients in a second RAM;
// per-entry valid bits, cleared by reset, make every history and coefficient
// read as zero until written, so the block is usable right after reset with
// no clearing pass. A finished result sits in an output register, and the
// next transaction is accepted while it waits to be taken. Configuration
// writes are meant for idle periods.
// ----------------------------------------------------------------------------
module bandpass_iir_direct_form (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [bpf_pkg::CFG_IX_W-1:0]        cfg_index,
  input  logic [bpf_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                mode,
  input  logic signed [bpf_pkg::SAMPLE_W-1:0] sample,
  input  logic [bpf_pkg::IDX_W-1:0]           coef_index,
  input  logic signed [bpf_pkg::COEF_W-1:0]   coef_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bpf_pkg::SAMPLE_W-1:0] filtered
);

  logic [bpf_pkg::GAIN_W-1:0]    gain;
  logic [bpf_pkg::SHIFT_W-1:0]   gain_shift;
  logic                          hist_we;
  logic [bpf_pkg::HM_W-1:0]      hist_waddr;
  logic [bpf_pkg::SAMPLE_W-1:0]  hist_wdata;
  logic [bpf_pkg::HM_W-1:0]      hist_raddr;
  logic [bpf_pkg::SAMPLE_W-1:0]  hist_rdata;
  logic                          coef_we;
  logic [bpf_pkg::CA_W-1:0]      coef_waddr;
  logic [bpf_pkg::CA_W-1:0]      coef_raddr;
  logic [bpf_pkg::COEF_W-1:0]    coef_rdata;
  logic signed [bpf_pkg::SAMPLE_W-1:0] y;
  bpf_pkg::dp_ctl_t              ctl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain       <= '1;
      gain_shift <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bpf_pkg::REG_GAIN:       gain       <= cfg_data[bpf_pkg::GAIN_W-1:0];
        bpf_pkg::REG_GAIN_SHIFT: gain_shift <= cfg_data[bpf_pkg::SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Input and output history rings.
  bpf_ram #(
    .WIDTH (bpf_pkg::SAMPLE_W),
    .DEPTH (bpf_pkg::HIST_MEM_D)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Feedback coefficients.
  bpf_ram #(
    .WIDTH (bpf_pkg::COEF_W),
    .DEPTH (bpf_pkg::FB_TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (coef_value),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  // Sequencer.
  bpf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .coef_index (coef_index),
    .sample     (sample),
    .y          (y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_wdata (hist_wdata),
    .hist_raddr (hist_raddr),
    .coef_we    (coef_we),
    .coef_waddr (coef_waddr),
    .coef_raddr (coef_raddr),
    .ctl        (ctl)
  );

  // Multiply-accumulate datapath.
  bpf_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .hist_rdata (hist_rdata),
    .coef_rdata (coef_rdata),
    .gain       (gain),
    .gain_shift (gain_shift),
    .y          (y),
    .filtered   (filtered)
  );

endmodule
